// ===== design/sss_pkg.sv =====
// Package for the sliced round-robin resource block group scheduler.
// Holds the beat types, the opcode codes and the controller states.
// No dependencies.
package sss_pkg;

  typedef enum logic [2:0] {
    OP_SCHED      = 3'd0,
    OP_MAP_WR     = 3'd1,
    OP_RNTI_WR    = 3'd2,
    OP_MEMBER_WR  = 3'd3,
    OP_SLICE_WR   = 3'd4
  } opcode_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  subframe;
    logic [4:0]  group_index;
    logic [3:0]  user_slot;
    logic [2:0]  member_slot;
    logic [2:0]  slice_slot;
    logic [15:0] rnti_value;
    logic [31:0] slice_value;
  } in_beat_t;

  typedef struct packed {
    logic [4:0]  out_group;
    logic [15:0] assigned_rnti;
    logic        is_last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_SLICE,
    ST_GSCAN,
    ST_USER,
    ST_MEMB,
    ST_ASSIGN,
    ST_EMIT
  } state_t;

endpackage

// ===== design/slice_static_rr_prb_scheduler.sv =====
// Top level of the sliced round-robin resource block group scheduler. Depends on sss_pkg, sss_ram.
// Write beats are taken only in the idle state. A schedule beat starts a walk over the slices: for
// each valid slice the group owner map is scanned and, for a slice with mapped groups, users are
// probed round-robin, and each probed user with a nonzero rnti has its membership row read.
// NUM_GROUPS result beats follow, one per cycle unless stalled; input is taken again after the last.
// Reset starts a clearing pass over max(NUM_SUBFRAMES*NUM_GROUPS, NUM_USERS*NUM_SLICES) RAM addresses.
module slice_static_rr_prb_scheduler #(
  parameter int NUM_USERS     = 16,
  parameter int NUM_SLICES    = 8,
  parameter int NUM_GROUPS    = 32,
  parameter int NUM_SUBFRAMES = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sss_pkg::in_beat_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sss_pkg::out_beat_t out_data
);
  import sss_pkg::*;

  localparam int MAP_D = NUM_SUBFRAMES * NUM_GROUPS;
  localparam int MEM_D = NUM_USERS * NUM_SLICES;
  localparam int MAW   = MAP_D > 1 ? $clog2(MAP_D) : 1;
  localparam int MEW   = MEM_D > 1 ? $clog2(MEM_D) : 1;
  localparam int CLR_LEN = MAP_D > MEM_D ? MAP_D : MEM_D;
  localparam int CW    = $clog2(CLR_LEN + 1);
  localparam int GW    = NUM_GROUPS > 1 ? $clog2(NUM_GROUPS) : 1;
  localparam int GCW   = $clog2(NUM_GROUPS + 1);
  localparam int SW    = NUM_SLICES > 1 ? $clog2(NUM_SLICES) : 1;
  localparam int SCW   = $clog2(NUM_SLICES + 1);
  localparam int UW    = $clog2(NUM_USERS);
  localparam int UCW   = $clog2(NUM_USERS + 1);
  localparam int MCW   = $clog2(NUM_SLICES + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0]  clr_r;
  logic [3:0]     sfm_r;
  logic [3:0]     sf_mod;
  logic [SCW-1:0] s_r;
  logic [31:0]    id_r;
  logic [GCW-1:0] g_r;
  logic           pend_r;
  logic [GW-1:0]  pidx_r;
  logic [NUM_GROUPS-1:0] mask_r;
  logic [UW-1:0]  u_r;
  logic [UCW-1:0] n_r;
  logic [MCW-1:0] m_r;
  logic           mpend_r;
  logic           hit_r;
  logic [GCW-1:0] e_r;
  logic           out_valid_r;
  out_beat_t      out_data_r;

  logic [15:0] rnti_r [NUM_USERS];
  logic [31:0] sid_r  [NUM_SLICES];
  logic [UW-1:0] ptr_r [NUM_SLICES];
  logic [15:0] asg_r  [NUM_GROUPS];

  logic           accept;
  logic           emit_load;
  logic           map_we, mem_we;
  logic [MAW-1:0] map_waddr, map_raddr;
  logic [MEW-1:0] mem_waddr, mem_raddr;
  logic [31:0]    map_wdata, mem_wdata, map_rdata, mem_rdata;
  logic [SW-1:0]  s_idx;
  logic [31:0]    cur_sid;
  logic [UW-1:0]  u_inc;
  logic [UW-1:0]  u_start;

  assign accept    = in_valid && !in_stall;
  assign emit_load = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  assign s_idx     = s_r[SW-1:0];
  assign cur_sid   = sid_r[s_idx];
  assign u_inc     = (int'(u_r) == NUM_USERS - 1) ? '0 : u_r + 1'b1;
  assign u_start   = (int'(ptr_r[s_idx]) == NUM_USERS - 1) ? '0 : ptr_r[s_idx] + 1'b1;

  always_comb begin
    sf_mod = '0;
    for (int i = 0; i < 16; i++) begin
      if (in_data.subframe == 4'(i)) begin
        sf_mod = 4'(i % NUM_SUBFRAMES);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (int'(clr_r) == CLR_LEN - 1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_data.opcode == OP_SCHED) state_nxt = ST_SLICE;
      end
      ST_SLICE: begin
        if (int'(s_r) == NUM_SLICES) state_nxt = ST_EMIT;
        else if (cur_sid != '0) state_nxt = ST_GSCAN;
      end
      ST_GSCAN: begin
        if (int'(g_r) == NUM_GROUPS && !pend_r) begin
          state_nxt = (mask_r == '0) ? ST_SLICE : ST_USER;
        end
      end
      ST_USER: begin
        if (int'(n_r) == NUM_USERS) state_nxt = ST_SLICE;
        else if (rnti_r[u_r] != '0) state_nxt = ST_MEMB;
      end
      ST_MEMB: begin
        if (int'(m_r) == NUM_SLICES && !mpend_r) begin
          state_nxt = hit_r ? ST_ASSIGN : ST_USER;
        end
      end
      ST_ASSIGN: state_nxt = ST_SLICE;
      ST_EMIT: begin
        if (emit_load && int'(e_r) == NUM_GROUPS - 1) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    map_we    = 1'b0;
    mem_we    = 1'b0;
    map_waddr = MAW'(int'(sf_mod) * NUM_GROUPS + int'(in_data.group_index));
    mem_waddr = MEW'(int'(in_data.user_slot) * NUM_SLICES + int'(in_data.member_slot));
    map_wdata = in_data.slice_value;
    mem_wdata = in_data.slice_value;
    map_raddr = MAW'(int'(sfm_r) * NUM_GROUPS + int'(g_r));
    mem_raddr = MEW'(int'(u_r) * NUM_SLICES + int'(m_r));
    unique case (state_r)
      ST_CLR: begin
        map_waddr = MAW'(clr_r);
        mem_waddr = MEW'(clr_r);
        map_wdata = '0;
        mem_wdata = '0;
        map_we    = int'(clr_r) < MAP_D;
        mem_we    = int'(clr_r) < MEM_D;
      end
      ST_IDLE: begin
        map_we = accept && in_data.opcode == OP_MAP_WR &&
                 int'(in_data.group_index) < NUM_GROUPS;
        mem_we = accept && in_data.opcode == OP_MEMBER_WR &&
                 int'(in_data.user_slot) < NUM_USERS &&
                 int'(in_data.member_slot) < NUM_SLICES;
      end
      default: ;
    endcase
  end

  sss_ram #(.WIDTH(32), .DEPTH(MAP_D)) u_map (
    .clk(clk), .we(map_we), .waddr(map_waddr), .wdata(map_wdata),
    .raddr(map_raddr), .rdata(map_rdata)
  );

  sss_ram #(.WIDTH(32), .DEPTH(MEM_D)) u_member (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      mpend_r     <= 1'b0;
      for (int i = 0; i < NUM_USERS; i++) rnti_r[i] <= '0;
      for (int i = 0; i < NUM_SLICES; i++) begin
        sid_r[i] <= '0;
        ptr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall && !emit_load) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              OP_SCHED: begin
                for (int i = 0; i < NUM_GROUPS; i++) asg_r[i] <= '0;
                s_r   <= '0;
                e_r   <= '0;
                sfm_r <= sf_mod;
              end
              OP_RNTI_WR: begin
                if (int'(in_data.user_slot) < NUM_USERS) begin
                  rnti_r[UW'(in_data.user_slot)] <= in_data.rnti_value;
                end
              end
              OP_SLICE_WR: begin
                if (int'(in_data.slice_slot) < NUM_SLICES) begin
                  sid_r[SW'(in_data.slice_slot)] <= in_data.slice_value;
                  ptr_r[SW'(in_data.slice_slot)] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SLICE: begin
          if (int'(s_r) != NUM_SLICES) begin
            if (cur_sid == '0) begin
              s_r <= s_r + 1'b1;
            end else begin
              id_r   <= cur_sid;
              g_r    <= '0;
              mask_r <= '0;
            end
          end
        end
        ST_GSCAN: begin
          if (int'(g_r) < NUM_GROUPS) begin
            pend_r <= 1'b1;
            pidx_r <= g_r[GW-1:0];
            g_r    <= g_r + 1'b1;
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r) mask_r[pidx_r] <= (map_rdata == id_r);
          if (int'(g_r) == NUM_GROUPS && !pend_r) begin
            if (mask_r == '0) s_r <= s_r + 1'b1;
            u_r <= u_start;
            n_r <= '0;
          end
        end
        ST_USER: begin
          if (int'(n_r) == NUM_USERS) begin
            s_r <= s_r + 1'b1;
          end else if (rnti_r[u_r] == '0) begin
            u_r <= u_inc;
            n_r <= n_r + 1'b1;
          end else begin
            m_r   <= '0;
            hit_r <= 1'b0;
          end
        end
        ST_MEMB: begin
          if (int'(m_r) < NUM_SLICES) begin
            mpend_r <= 1'b1;
            m_r     <= m_r + 1'b1;
          end else begin
            mpend_r <= 1'b0;
          end
          if (mpend_r && mem_rdata == id_r) hit_r <= 1'b1;
          if (int'(m_r) == NUM_SLICES && !mpend_r && !hit_r) begin
            u_r <= u_inc;
            n_r <= n_r + 1'b1;
          end
        end
        ST_ASSIGN: begin
          for (int i = 0; i < NUM_GROUPS; i++) begin
            if (mask_r[i]) asg_r[i] <= rnti_r[u_r];
          end
          ptr_r[s_idx] <= u_r;
          s_r <= s_r + 1'b1;
        end
        ST_EMIT: begin
          if (emit_load) begin
            out_valid_r              <= 1'b1;
            out_data_r.out_group     <= 5'(e_r);
            out_data_r.assigned_rnti <= asg_r[e_r[GW-1:0]];
            out_data_r.is_last       <= (int'(e_r) == NUM_GROUPS - 1);
            e_r                      <= e_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sched_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.opcode == OP_SCHED |=> state_r == ST_SLICE)
    else $error("schedule beat did not start a run");

  a_no_emit_outside_run: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && state_r != ST_EMIT |=> !out_valid_r)
    else $error("result beat raised outside the emit phase");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    emit_load && int'(e_r) == NUM_GROUPS - 1 |=> out_data_r.is_last && state_r == ST_IDLE)
    else $error("final group did not close the run");

endmodule

// ===== design/sss_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
// Used for the group owner map and the user membership table. No dependencies.
module sss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 320
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
